@@ rtl/core/kcf_pkg.sv @@
`default_nettype none

package kcf_pkg;

  typedef enum logic [1:0] {
    OP_KEY       = 2'd0,
    OP_TICK      = 2'd1,
    OP_NET_ENQ   = 2'd2,
    OP_NET_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_PERF    = 2'd0,
    MODE_BALANCE = 2'd1,
    MODE_SAVER   = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  localparam int unsigned STAT_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned QKEYS_W = 7;
  localparam int unsigned TICK_W = 4;

  typedef struct packed {
    logic accept;
    logic drain_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_run;
    logic drain_last;
  } sts_t;

  function automatic logic [TICK_W-1:0] interval_of(input mode_t m);
    logic [TICK_W-1:0] r;
    case (m)
      MODE_PERF:  r = TICK_W'(1);
      MODE_SAVER: r = TICK_W'(12);
      default:    r = TICK_W'(3);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/kcf_ram.sv @@
`default_nettype none

module kcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kcf_ctrl.sv @@
`default_nettype none

module kcf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire kcf_pkg::sts_t sts,
  output      kcf_pkg::cmd_t cmd
);

  kcf_pkg::state_t state;
  kcf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.drain_load = 1'b0;
    in_stall       = 1'b1;
    case (state)
      kcf_pkg::ST_IDLE: begin
        in_stall   = !sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.flush_run) begin
          state_next = kcf_pkg::ST_DRAIN;
        end
      end
      kcf_pkg::ST_DRAIN: begin
        cmd.drain_load = sts.out_free;
        if (sts.out_free && sts.drain_last) begin
          state_next = kcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kcf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/kcf_dp.sv @@
`default_nettype none

module kcf_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kcf_pkg::cmd_t                  cmd,
  output      kcf_pkg::sts_t                  sts,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_mode,
  input  wire logic [1:0]                     op,
  input  wire logic [kcf_pkg::CHAR_W-1:0]     key_code,
  input  wire logic [kcf_pkg::STAT_W-1:0]     packet_count,
  input  wire logic [kcf_pkg::STAT_W-1:0]     byte_count,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           delivers_key,
  output      logic [kcf_pkg::CHAR_W-1:0]     out_char,
  output      logic                           last,
  output      logic                           net_kick,
  output      logic [kcf_pkg::QKEYS_W-1:0]    queued_keys,
  output      logic [kcf_pkg::STAT_W-1:0]     pending_packets,
  output      logic [kcf_pkg::STAT_W-1:0]     pending_bytes,
  output      logic [kcf_pkg::STAT_W-1:0]     wakeup_total,
  output      logic [kcf_pkg::STAT_W-1:0]     key_event_total,
  output      logic [kcf_pkg::STAT_W-1:0]     coalesced_total,
  output      logic [kcf_pkg::STAT_W-1:0]     key_flush_total,
  output      logic [kcf_pkg::STAT_W-1:0]     net_flush_total
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam int unsigned SW    = kcf_pkg::STAT_W;

  kcf_pkg::mode_t              mode;
  logic [IDX_W-1:0]            head, head_next, head_adv;
  logic [CNT_W-1:0]            count, count_next;
  logic [CNT_W-1:0]            drain, drain_next;
  logic [kcf_pkg::TICK_W-1:0]  tick, tick_next, tick_inc;
  logic [SW-1:0]               packets, packets_next;
  logic [SW-1:0]               bytes, bytes_next;
  logic [SW-1:0]               wakeups, wakeups_next;
  logic [SW-1:0]               keys, keys_next;
  logic [SW-1:0]               coalesced, coalesced_next;
  logic [SW-1:0]               kflush, kflush_next;
  logic [SW-1:0]               nflush, nflush_next;
  logic [SUM_W-1:0]            tail_sum, tail;
  logic                        ring_full, key_direct, reached;
  logic                        out_load;
  logic                        delivers_key_next, last_next, net_kick_next;
  logic [kcf_pkg::CHAR_W-1:0]  out_char_next;
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [kcf_pkg::CHAR_W-1:0]  ram_rdata;

  assign tail_sum   = SUM_W'(head) + SUM_W'(count);
  assign tail       = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                       : tail_sum;
  assign head_adv   = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign ring_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign key_direct = (mode == kcf_pkg::MODE_PERF) || ring_full;
  assign tick_inc   = tick + kcf_pkg::TICK_W'(1);
  assign reached    = (tick_inc >= kcf_pkg::interval_of(mode));

  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.flush_run  = (kcf_pkg::op_t'(op) == kcf_pkg::OP_TICK) && reached
                          && (count != '0);
  assign sts.drain_last = (drain == CNT_W'(1));

  assign ram_we    = cmd.accept && (kcf_pkg::op_t'(op) == kcf_pkg::OP_KEY) && !key_direct;
  assign ram_re    = (cmd.accept && sts.flush_run)
                     || (cmd.drain_load && (drain > CNT_W'(1)));
  assign ram_raddr = cmd.drain_load ? head_adv : head;

  kcf_ram #(
    .WIDTH (kcf_pkg::CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail[IDX_W-1:0]),
    .wdata (key_code),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_next         = head;
    count_next        = count;
    drain_next        = drain;
    tick_next         = tick;
    packets_next      = packets;
    bytes_next        = bytes;
    wakeups_next      = wakeups;
    keys_next         = keys;
    coalesced_next    = coalesced;
    kflush_next       = kflush;
    nflush_next       = nflush;
    out_load          = 1'b0;
    delivers_key_next = 1'b0;
    out_char_next     = '0;
    last_next         = 1'b1;
    net_kick_next     = 1'b0;
    if (cmd.accept) begin
      out_load = !sts.flush_run;
      case (kcf_pkg::op_t'(op))
        kcf_pkg::OP_KEY: begin
          keys_next = keys + SW'(1);
          if (key_direct) begin
            wakeups_next      = wakeups + SW'(1);
            delivers_key_next = 1'b1;
            out_char_next     = key_code;
          end else begin
            count_next     = count + CNT_W'(1);
            coalesced_next = coalesced + SW'(1);
          end
        end
        kcf_pkg::OP_TICK: begin
          tick_next = tick_inc;
          if (reached) begin
            tick_next     = '0;
            net_kick_next = 1'b1;
            if (count != '0) begin
              wakeups_next = wakeups + SW'(1);
              kflush_next  = kflush + SW'(1);
              count_next   = '0;
              drain_next   = count;
            end
          end
        end
        kcf_pkg::OP_NET_ENQ: begin
          packets_next = packets + SW'(1);
          bytes_next   = bytes + byte_count;
        end
        kcf_pkg::OP_NET_FLUSH: begin
          if (packet_count != '0) begin
            wakeups_next = wakeups + SW'(1);
            nflush_next  = nflush + SW'(1);
            packets_next = (packets >= packet_count) ? packets - packet_count : '0;
            bytes_next   = (bytes >= byte_count) ? bytes - byte_count : '0;
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
    if (cmd.drain_load) begin
      out_load          = 1'b1;
      delivers_key_next = 1'b1;
      out_char_next     = ram_rdata;
      last_next         = sts.drain_last;
      net_kick_next     = 1'b1;
      drain_next        = drain - CNT_W'(1);
      head_next         = head_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= kcf_pkg::MODE_BALANCE;
      head      <= '0;
      count     <= '0;
      drain     <= '0;
      tick      <= '0;
      packets   <= '0;
      bytes     <= '0;
      wakeups   <= '0;
      keys      <= '0;
      coalesced <= '0;
      kflush    <= '0;
      nflush    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && (kcf_pkg::mode_t'(cfg_mode) != kcf_pkg::MODE_INVALID)) begin
        mode <= kcf_pkg::mode_t'(cfg_mode);
      end
      head      <= head_next;
      count     <= count_next;
      drain     <= drain_next;
      tick      <= tick_next;
      packets   <= packets_next;
      bytes     <= bytes_next;
      wakeups   <= wakeups_next;
      keys      <= keys_next;
      coalesced <= coalesced_next;
      kflush    <= kflush_next;
      nflush    <= nflush_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      delivers_key <= delivers_key_next;
      out_char     <= out_char_next;
      last         <= last_next;
      net_kick     <= net_kick_next;
    end
  end

  assign queued_keys     = kcf_pkg::QKEYS_W'(count);
  assign pending_packets = packets;
  assign pending_bytes   = bytes;
  assign wakeup_total    = wakeups;
  assign key_event_total = keys;
  assign coalesced_total = coalesced;
  assign key_flush_total = kflush;
  assign net_flush_total = nflush;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("ring count above depth");

  a_no_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !delivers_key) |-> (out_char == '0))
    else $error("character on a beat without delivery");

  a_drain_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_load |-> (drain != '0))
    else $error("drain step with nothing left");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.flush_run) |=> (count == '0) && (drain != '0))
    else $error("flush did not take the whole ring");
`endif

endmodule

`default_nettype wire

@@ rtl/core/keystroke_coalescing_flush.sv @@
// Keystroke coalescer with timed flush and network pending counters.
// Input channel: in_valid/in_stall carrying op, key_code, packet_count and
// byte_count; a beat moves when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall; each beat carries delivers_key,
// out_char, last, net_kick and the status counters after the whole item.
// Config channel: cfg_valid/cfg_ready with power_mode; cfg_ready is always
// high, a write of 3 is ignored.
// Results: a single-result item shows its beat in the cycle after acceptance.
// A tick that flushes N queued keys reads the ring memory one key ahead and
// emits one key per cycle while the output is not stalled; the first key
// passes through the ring read register and then the output register.
// Items are taken one at a time: in_stall is high while a flush drains and
// while an output beat is stalled, so a stalled receiver holds the result
// register and backs up the input.
// Reset (rst, synchronous): counters, ring pointers and out_valid
// clear, power_mode returns to balanced; ring contents and beat fields are not cleared.
`default_nettype none

module keystroke_coalescing_flush #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [1:0]                  power_mode,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [1:0]                  op,
  input  wire logic [kcf_pkg::CHAR_W-1:0]  key_code,
  input  wire logic [kcf_pkg::STAT_W-1:0]  packet_count,
  input  wire logic [kcf_pkg::STAT_W-1:0]  byte_count,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic                        delivers_key,
  output      logic [kcf_pkg::CHAR_W-1:0]  out_char,
  output      logic                        last,
  output      logic                        net_kick,
  output      logic [kcf_pkg::QKEYS_W-1:0] queued_keys,
  output      logic [kcf_pkg::STAT_W-1:0]  pending_packets,
  output      logic [kcf_pkg::STAT_W-1:0]  pending_bytes,
  output      logic [kcf_pkg::STAT_W-1:0]  wakeup_total,
  output      logic [kcf_pkg::STAT_W-1:0]  key_event_total,
  output      logic [kcf_pkg::STAT_W-1:0]  coalesced_total,
  output      logic [kcf_pkg::STAT_W-1:0]  key_flush_total,
  output      logic [kcf_pkg::STAT_W-1:0]  net_flush_total
);

  kcf_pkg::cmd_t cmd;
  kcf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  kcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kcf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_mode        (power_mode),
    .op              (op),
    .key_code        (key_code),
    .packet_count    (packet_count),
    .byte_count      (byte_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .delivers_key    (delivers_key),
    .out_char        (out_char),
    .last            (last),
    .net_kick        (net_kick),
    .queued_keys     (queued_keys),
    .pending_packets (pending_packets),
    .pending_bytes   (pending_bytes),
    .wakeup_total    (wakeup_total),
    .key_event_total (key_event_total),
    .coalesced_total (coalesced_total),
    .key_flush_total (key_flush_total),
    .net_flush_total (net_flush_total)
  );

endmodule

`default_nettype wire
